### rtl/core/ccse_pkg.sv
package ccse_pkg;

	// stream payload widths
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 64;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 16;

	// heights in quarter units, positions in 1/512 pixel
	localparam int ZS_W  = 18;
	localparam int POS_W = 29;
	localparam int NUM_W = 35;
	localparam int DEN_W = 18;
	localparam int QUO_W = 17;
	localparam int DIV_STAGES = 6;
	localparam int DIV_STEPS  = 3;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_LEVEL    = 3'd0,
		REG_CELL_W   = 3'd1,
		REG_CELL_H   = 3'd2,
		REG_ORIGIN_X = 3'd3,
		REG_ORIGIN_Y = 3'd4
	} reg_idx_t;

	// vertices: 0 top-left, 1 top-right, 2 bottom-right, 3 bottom-left, 4 center
	// per triangle: edges a-b, a-c, c-b
	localparam logic [2:0] EDGE_VA [4][3] = '{
		'{3'd0, 3'd0, 3'd4},
		'{3'd1, 3'd1, 3'd2},
		'{3'd4, 3'd4, 3'd2},
		'{3'd0, 3'd0, 3'd3}
	};
	localparam logic [2:0] EDGE_VB [4][3] = '{
		'{3'd1, 3'd4, 3'd1},
		'{3'd4, 3'd2, 3'd4},
		'{3'd3, 3'd2, 3'd3},
		'{3'd4, 3'd3, 3'd4}
	};

	typedef struct packed {
		logic [1:0]            tid;
		logic                  last;
		logic [3:0]            neg;
		logic [3:0][POS_W-1:0] pa;
	} side_t;

	// vertex offset in half cells
	function automatic logic [1:0] vx_off(input logic [2:0] v);
		case (v)
			3'd1, 3'd2: return 2'd2;
			3'd4:       return 2'd1;
			default:    return 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] vy_off(input logic [2:0] v);
		case (v)
			3'd2, 3'd3: return 2'd2;
			3'd4:       return 2'd1;
			default:    return 2'd0;
		endcase
	endfunction

	function automatic logic crosses(input logic signed [ZS_W-1:0] lv,
			input logic signed [ZS_W-1:0] za, input logic signed [ZS_W-1:0] zb);
		return (za != zb) && ((lv <= za && lv >= zb) || (lv >= za && lv <= zb));
	endfunction

	function automatic logic [15:0] to_pix(input logic [POS_W-1:0] c);
		return (|c[POS_W-1:25]) ? 16'hFFFF : c[24:9];
	endfunction

endpackage

### rtl/core/ccse_div.sv
module ccse_div import ccse_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo,
	output logic             rem_nz
);

	// num < den * 2^QUO_W, so the upper part starts below den
	logic [DEN_W-1:0] rem_s [DIV_STAGES];
	logic [QUO_W-1:0] nq_s  [DIV_STAGES];
	logic [DEN_W-1:0] den_s [DIV_STAGES];

	for (genvar st = 0; st < DIV_STAGES; st++) begin : g_st
		logic [DEN_W-1:0] r_in, d_in, r_nx;
		logic [QUO_W-1:0] q_in, q_nx;

		if (st == 0) begin : g_first
			assign r_in = num[NUM_W-1:QUO_W];
			assign q_in = num[QUO_W-1:0];
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[st-1];
			assign q_in = nq_s[st-1];
			assign d_in = den_s[st-1];
		end

		// numerator bits shift out the top, quotient bits shift in below
		always_comb begin
			logic [DEN_W:0]   wide;
			logic [DEN_W-1:0] r;
			logic [QUO_W-1:0] q;
			r = r_in;
			q = q_in;
			wide = '0;
			for (int i = 0; i < DIV_STEPS; i++) begin
				if (st * DIV_STEPS + i < QUO_W) begin
					wide = {r, q[QUO_W-1]};
					q = {q[QUO_W-2:0], (wide >= {1'b0, d_in})};
					if (q[0]) begin
						r = DEN_W'(wide - {1'b0, d_in});
					end else begin
						r = wide[DEN_W-1:0];
					end
				end
			end
			r_nx = r;
			q_nx = q;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[st] <= r_nx;
				nq_s[st]  <= q_nx;
				den_s[st] <= d_in;
			end
		end
	end

	assign quo    = nq_s[DIV_STAGES-1];
	assign rem_nz = |rem_s[DIV_STAGES-1];

endmodule

### rtl/core/contour_cell_segment_extract.sv
// Contour segment extractor, four triangles per grid cell.
// s_tdata carries one cell per beat; configuration is written through
// cfg_we / cfg_addr / cfg_wdata while no cell is in flight.
// Each cell is held in an input register and issued as four triangle beats,
// one per cycle unless the receiver stalls, and the next cell is taken as
// the last beat issues. Triangles without a segment become bubbles; each
// segment leaves as one m_tdata beat, m_tuser giving the triangle and m_tlast
// marking the cell's final segment.
// The pipeline is: triangle select, edge distances and cell products,
// position and numerator multiply, six stages of a 17-bit restoring
// divider (up to three quotient bits per stage), sign fix-up, then the output
// register with pixel truncation and saturation.
// The input register loads whenever it is empty, so one cell can be taken
// during a stall of the receiver. A stall freezes every stage; nothing
// is dropped or repeated.
// Reset clears the valid bits and loads the register defaults: level 0,
// cell size 1.0 x 1.0 pixel, origin 0,0.
module contour_cell_segment_extract import ccse_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// cell_col, cell_row, z_top_left, z_top_right, z_bottom_right, z_bottom_left
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// seg_x_start, seg_y_start, seg_x_end, seg_y_end
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// triangle_id
	output logic [1:0]             m_tuser,
	output logic                   m_tlast
);

	logic signed [15:0] level_q;
	logic [15:0]        cw_q, ch_q;
	logic [11:0]        ox_q, oy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			cw_q    <= 16'd256;
			ch_q    <= 16'd256;
			ox_q    <= '0;
			oy_q    <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_LEVEL:    level_q <= cfg_wdata;
				REG_CELL_W:   cw_q    <= cfg_wdata;
				REG_CELL_H:   ch_q    <= cfg_wdata;
				REG_ORIGIN_X: ox_q    <= cfg_wdata[11:0];
				REG_ORIGIN_Y: oy_q    <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	logic en, accept;
	logic m_tvalid_q;

	assign en = !m_tvalid_q || m_tready;

	// input hold register and triangle counter
	logic                      hold_v_q;
	logic [1:0]                beat_q;
	logic [9:0]                col_q, row_q;
	logic signed [15:0]        z_q [4];
	logic signed [ZS_W-1:0]    zsum_q;

	assign s_tready = !hold_v_q || (en && beat_q == 2'd3);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			beat_q   <= '0;
		end else if (accept) begin
			hold_v_q <= 1'b1;
			beat_q   <= '0;
		end else if (en && hold_v_q) begin
			beat_q <= beat_q + 2'd1;
			if (beat_q == 2'd3) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q  <= s_tdata[9:0];
			row_q  <= s_tdata[19:10];
			z_q[0] <= s_tdata[35:20];
			z_q[1] <= s_tdata[51:36];
			z_q[2] <= s_tdata[67:52];
			z_q[3] <= s_tdata[83:68];
			zsum_q <= ZS_W'($signed(s_tdata[35:20])) + ZS_W'($signed(s_tdata[51:36]))
				+ ZS_W'($signed(s_tdata[67:52])) + ZS_W'($signed(s_tdata[83:68]));
		end
	end

	// triangle select
	logic signed [ZS_W-1:0] lv4;
	logic signed [ZS_W-1:0] zs [5];
	logic signed [ZS_W-1:0] za_all [4][3];
	logic signed [ZS_W-1:0] zb_all [4][3];
	logic [2:0]             cr_all [4];
	logic [3:0]             emit_all, last_all;
	logic [1:0]             sel0, sel1;

	assign lv4 = {level_q, 2'b00};

	always_comb begin
		for (int v = 0; v < 4; v++) begin
			zs[v] = {z_q[v], 2'b00};
		end
		zs[4] = zsum_q;
		for (int t = 0; t < 4; t++) begin
			for (int e = 0; e < 3; e++) begin
				za_all[t][e] = zs[EDGE_VA[t][e]];
				zb_all[t][e] = zs[EDGE_VB[t][e]];
				cr_all[t][e] = crosses(lv4, za_all[t][e], zb_all[t][e]);
			end
			emit_all[t] = (cr_all[t][0] && cr_all[t][1] && !cr_all[t][2])
				|| (cr_all[t][0] && !cr_all[t][1] && cr_all[t][2])
				|| (!cr_all[t][0] && cr_all[t][1] && cr_all[t][2]);
		end
		for (int t = 0; t < 4; t++) begin
			last_all[t] = emit_all[t] && ((emit_all >> (t + 1)) == 4'd0);
		end
		sel0 = cr_all[beat_q][0] ? 2'd0 : 2'd1;
		sel1 = (cr_all[beat_q][0] && cr_all[beat_q][1]) ? 2'd1 : 2'd2;
	end

	logic                   v_s1, last_s1;
	logic [1:0]             tid_s1;
	logic [9:0]             col_s1, row_s1;
	logic signed [ZS_W-1:0] za_s1 [2];
	logic signed [ZS_W-1:0] zb_s1 [2];
	logic [2:0]             va_s1 [2];
	logic [2:0]             vb_s1 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= hold_v_q && emit_all[beat_q];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tid_s1   <= beat_q;
			last_s1  <= last_all[beat_q];
			col_s1   <= col_q;
			row_s1   <= row_q;
			za_s1[0] <= za_all[beat_q][sel0];
			zb_s1[0] <= zb_all[beat_q][sel0];
			va_s1[0] <= EDGE_VA[beat_q][sel0];
			vb_s1[0] <= EDGE_VB[beat_q][sel0];
			za_s1[1] <= za_all[beat_q][sel1];
			zb_s1[1] <= zb_all[beat_q][sel1];
			va_s1[1] <= EDGE_VA[beat_q][sel1];
			vb_s1[1] <= EDGE_VB[beat_q][sel1];
		end
	end

	// distances along the height axis and cell products
	logic             v_s2, last_s2;
	logic [1:0]       tid_s2;
	logic [25:0]      pcol_s2, prow_s2;
	logic [DEN_W-1:0] t_s2 [2];
	logic [DEN_W-1:0] d_s2 [2];
	logic [1:0]       kmag_s2 [4];
	logic             kneg_s2 [4];
	logic [1:0]       offa_s2 [4];

	logic signed [ZS_W:0] dt [2];
	logic signed [ZS_W:0] dd [2];
	logic signed [2:0]    kx [2];
	logic signed [2:0]    ky [2];

	always_comb begin
		for (int e = 0; e < 2; e++) begin
			dt[e] = (ZS_W+1)'(lv4) - (ZS_W+1)'(za_s1[e]);
			dd[e] = (ZS_W+1)'(zb_s1[e]) - (ZS_W+1)'(za_s1[e]);
			kx[e] = $signed({1'b0, vx_off(vb_s1[e])}) - $signed({1'b0, vx_off(va_s1[e])});
			ky[e] = $signed({1'b0, vy_off(vb_s1[e])}) - $signed({1'b0, vy_off(va_s1[e])});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tid_s2  <= tid_s1;
			last_s2 <= last_s1;
			pcol_s2 <= {10'd0, cw_q} * {16'd0, col_s1};
			prow_s2 <= {10'd0, ch_q} * {16'd0, row_s1};
			for (int e = 0; e < 2; e++) begin
				t_s2[e] <= dt[e][ZS_W] ? DEN_W'(-dt[e]) : DEN_W'(dt[e]);
				d_s2[e] <= dd[e][ZS_W] ? DEN_W'(-dd[e]) : DEN_W'(dd[e]);
				kneg_s2[2*e]   <= kx[e][2];
				kmag_s2[2*e]   <= kx[e][2] ? 2'(-kx[e]) : kx[e][1:0];
				offa_s2[2*e]   <= vx_off(va_s1[e]);
				kneg_s2[2*e+1] <= ky[e][2];
				kmag_s2[2*e+1] <= ky[e][2] ? 2'(-ky[e]) : ky[e][1:0];
				offa_s2[2*e+1] <= vy_off(va_s1[e]);
			end
		end
	end

	// start positions and numerators
	logic             v_s3;
	side_t            side_s3;
	logic [NUM_W-1:0] num_s3 [4];
	logic [DEN_W-1:0] den_s3 [2];

	logic [POS_W-1:0] base [2];
	logic [16:0]      magd [4];
	logic [16:0]      offa [4];
	logic [15:0]      csz  [2];

	always_comb begin
		base[0] = POS_W'({ox_q, 9'd0}) + POS_W'({pcol_s2, 1'b0});
		base[1] = POS_W'({oy_q, 9'd0}) + POS_W'({prow_s2, 1'b0});
		csz[0] = cw_q;
		csz[1] = ch_q;
		for (int k = 0; k < 4; k++) begin
			case (kmag_s2[k])
				2'd2:    magd[k] = {csz[k%2], 1'b0};
				2'd1:    magd[k] = {1'b0, csz[k%2]};
				default: magd[k] = '0;
			endcase
			case (offa_s2[k])
				2'd2:    offa[k] = {csz[k%2], 1'b0};
				2'd1:    offa[k] = {1'b0, csz[k%2]};
				default: offa[k] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.tid  <= tid_s2;
			side_s3.last <= last_s2;
			for (int k = 0; k < 4; k++) begin
				side_s3.neg[k] <= kneg_s2[k];
				side_s3.pa[k]  <= base[k%2] + POS_W'(offa[k]);
				num_s3[k]      <= {17'd0, t_s2[k/2]} * {18'd0, magd[k]};
			end
			den_s3[0] <= d_s2[0];
			den_s3[1] <= d_s2[1];
		end
	end

	// dividers, index: edge*2 + axis
	logic [QUO_W-1:0] quo [4];
	logic             rem_nz [4];

	for (genvar k = 0; k < 4; k++) begin : g_div
		ccse_div u_div (
			.clk    (clk),
			.en     (en),
			.num    (num_s3[k]),
			.den    (den_s3[k/2]),
			.quo    (quo[k]),
			.rem_nz (rem_nz[k])
		);
	end

	logic  dv_v_s [DIV_STAGES];
	side_t dv_s   [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				dv_v_s[i] <= 1'b0;
			end
		end else if (en) begin
			dv_v_s[0] <= v_s3;
			for (int i = 1; i < DIV_STAGES; i++) begin
				dv_v_s[i] <= dv_v_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= side_s3;
			for (int i = 1; i < DIV_STAGES; i++) begin
				dv_s[i] <= dv_s[i-1];
			end
		end
	end

	// floor toward the edge direction: a negative step rounds away from the start
	logic                    v_s10, last_s10;
	logic [1:0]              tid_s10;
	logic signed [QUO_W:0]   qs_s10 [4];
	logic [POS_W-1:0]        pa_s10 [4];
	logic [QUO_W:0]          qmag [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			qmag[k] = {1'b0, quo[k]} + (QUO_W+1)'(rem_nz[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= dv_v_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tid_s10  <= dv_s[DIV_STAGES-1].tid;
			last_s10 <= dv_s[DIV_STAGES-1].last;
			for (int k = 0; k < 4; k++) begin
				pa_s10[k] <= dv_s[DIV_STAGES-1].pa[k];
				qs_s10[k] <= dv_s[DIV_STAGES-1].neg[k] ? -$signed(qmag[k])
					: $signed({1'b0, quo[k]});
			end
		end
	end

	// output register
	logic [POS_W-1:0]       coord [4];
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [1:0]             m_tuser_q;
	logic                   m_tlast_q;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			coord[k] = pa_s10[k] + POS_W'(qs_s10[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= {to_pix(coord[3]), to_pix(coord[2]), to_pix(coord[1]),
				to_pix(coord[0])};
			m_tuser_q <= tid_s10;
			m_tlast_q <= last_s10;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> hold_v_q && beat_q == 2'd0)
		else $error("accepted cell does not start at triangle 0");

	a_no_issue_empty: assert property (@(posedge clk) disable iff (!arst_n)
		en && !hold_v_q |=> !v_s1)
		else $error("triangle issued without a held cell");

	a_stall_holds_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!en && hold_v_q |=> $stable(beat_q))
		else $error("triangle counter moved during a stall");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb import ccse_pkg::*; ();

	typedef struct packed {
		logic [15:0] z_bl;
		logic [15:0] z_br;
		logic [15:0] z_tr;
		logic [15:0] z_tl;
		logic [9:0]  row;
		logic [9:0]  col;
	} cell_t;

	typedef struct {
		logic [63:0] xy;
		logic [1:0]  tid;
		logic        last;
	} seg_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic s_tvalid, s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	contour_cell_segment_extract dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	// shadow registers
	logic signed [15:0] lvl_q;
	logic [15:0] cw_q, ch_q;
	logic [11:0] ox_q, oy_q;

	cell_t cell_queue[$];
	seg_t seg_queue[$];
	int errors;
	longint cycles;
	int gap_left, burst_left, stall_mode;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic longint floor_interp(longint pa, longint pb, longint za, longint zb,
			longint lv);
		longint num, den, q;
		num = (lv - za) * (pb - pa);
		den = zb - za;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		q = num / den;
		if (num < 0 && q * den != num)
			q -= 1;
		return pa + q;
	endfunction

	function automatic logic [15:0] pixel_of(longint v);
		if (v < 0)
			return 16'd0;
		if (v / 512 > 65535)
			return 16'hFFFF;
		return 16'(v / 512);
	endfunction

	// segments for one cell, appended to seg_queue
	task automatic predict_segments(input cell_t c);
		longint px[5], py[5], pz[5], cx[3], cy[3];
		longint x0, y0, lv, za, zb;
		int va, vb, cnt, first_idx;
		seg_t s;
		x0 = longint'(ox_q) * 512 + 2 * longint'(cw_q) * longint'(c.col);
		y0 = longint'(oy_q) * 512 + 2 * longint'(ch_q) * longint'(c.row);
		lv = 4 * longint'(lvl_q);
		px[0] = x0; py[0] = y0;
		px[1] = x0 + 2 * cw_q; py[1] = y0;
		px[2] = x0 + 2 * cw_q; py[2] = y0 + 2 * ch_q;
		px[3] = x0; py[3] = y0 + 2 * ch_q;
		px[4] = x0 + cw_q; py[4] = y0 + ch_q;
		pz[0] = 4 * longint'($signed(c.z_tl));
		pz[1] = 4 * longint'($signed(c.z_tr));
		pz[2] = 4 * longint'($signed(c.z_br));
		pz[3] = 4 * longint'($signed(c.z_bl));
		pz[4] = (pz[0] + pz[1] + pz[2] + pz[3]) / 4;
		first_idx = seg_queue.size();
		for (int t = 0; t < 4; t++) begin
			cnt = 0;
			for (int e = 0; e < 3; e++) begin
				va = int'(EDGE_VA[t][e]);
				vb = int'(EDGE_VB[t][e]);
				za = pz[va];
				zb = pz[vb];
				if (za != zb && ((lv <= za && lv >= zb) || (lv >= za && lv <= zb))) begin
					cx[cnt] = floor_interp(px[va], px[vb], za, zb, lv);
					cy[cnt] = floor_interp(py[va], py[vb], za, zb, lv);
					cnt++;
				end
			end
			if (cnt == 2) begin
				s.xy = {pixel_of(cy[1]), pixel_of(cx[1]), pixel_of(cy[0]), pixel_of(cx[0])};
				s.tid = 2'(t);
				s.last = 1'b0;
				seg_queue.push_back(s);
			end
		end
		if (seg_queue.size() > first_idx)
			seg_queue[seg_queue.size() - 1].last = 1'b1;
	endtask

	// driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_segments(cell_t'(s_tdata[83:0]));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					s_tvalid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (cell_queue.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= IN_TDATA_W'(cell_queue.pop_front());
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_mode <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (seg_queue.size() == 0) begin
					$display("%0t unexpected beat: actual %h tid %0d last %0d",
						$time, m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					seg_t s;
					s = seg_queue.pop_front();
					if (m_tdata[15:0] !== s.xy[15:0] || m_tdata[31:16] !== s.xy[31:16] ||
							m_tdata[47:32] !== s.xy[47:32] || m_tdata[63:48] !== s.xy[63:48] ||
							m_tuser !== s.tid || m_tlast !== s.last) begin
						$display("%0t mismatch: expected %h tid %0d last %0d, actual %h tid %0d last %0d",
							$time, s.xy, s.tid, s.last, m_tdata, m_tuser, m_tlast);
						errors++;
					end
				end
			end
			if ($urandom_range(0, 63) == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 1) != 0);
				default: m_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("contour_cell_segment_extract test failed");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LEVEL:    lvl_q = val;
			REG_CELL_W:   cw_q = val;
			REG_CELL_H:   ch_q = val;
			REG_ORIGIN_X: ox_q = val[11:0];
			default:      oy_q = val[11:0];
		endcase
	endtask

	task automatic wait_drained();
		while (cell_queue.size() > 0 || s_tvalid || seg_queue.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [15:0] near_level(input logic signed [15:0] lv);
		int v;
		v = int'(lv) + $signed($urandom_range(0, 200)) - 100;
		if ($urandom_range(0, 9) == 0)
			return lv;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	function automatic cell_t rand_cell(input logic signed [15:0] lv);
		cell_t c;
		c.col = 10'($urandom);
		c.row = 10'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			c.z_tl = 16'($urandom); c.z_tr = 16'($urandom);
			c.z_br = 16'($urandom); c.z_bl = 16'($urandom);
		end else begin
			c.z_tl = near_level(lv); c.z_tr = near_level(lv);
			c.z_br = near_level(lv); c.z_bl = near_level(lv);
		end
		return c;
	endfunction

	function automatic cell_t mk(input logic [9:0] col, row, input logic [15:0] a, b, d, e);
		cell_t c;
		c.col = col; c.row = row; c.z_tl = a; c.z_tr = b; c.z_br = d; c.z_bl = e;
		return c;
	endfunction

	initial begin
		logic signed [15:0] lv;
		errors = 0;
		cycles = 0;
		cfg_we = 0;
		cfg_addr = '0;
		cfg_wdata = '0;
		lvl_q = 0; cw_q = 256; ch_q = 256; ox_q = 0; oy_q = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed cells at reset settings
		cell_queue.push_back(mk(10'd0, 10'd0, 16'd10, -16'sd10, 16'd10, -16'sd10));
		cell_queue.push_back(mk(10'h3FF, 10'h3FF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
		cell_queue.push_back(mk(10'd5, 10'd7, 16'd0, 16'd5, 16'd5, 16'd5));   // vertex on level
		cell_queue.push_back(mk(10'd5, 10'd7, 16'd0, 16'd0, 16'd0, 16'd0));   // all flat
		cell_queue.push_back(mk(10'd3, 10'd3, 16'd0, 16'd4, -16'sd4, 16'd0)); // three crossings
		cell_queue.push_back(mk(10'd1, 10'd2, -16'sd3, -16'sd3, 16'd9, 16'd9));
		cell_queue.push_back(mk(10'h2AA, 10'h155, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF));
		cell_queue.push_back(mk(10'h155, 10'h2AA, 16'd1, 16'd2, 16'd3, -16'sd1));
		wait_drained();

		// extremes: big cells and origin to force saturation
		write_reg(REG_CELL_W, 16'hFFFF);
		write_reg(REG_CELL_H, 16'hFFFF);
		write_reg(REG_ORIGIN_X, 16'hFFF);
		write_reg(REG_ORIGIN_Y, 16'hFFF);
		write_reg(REG_LEVEL, 16'h7FFF);
		cell_queue.push_back(mk(10'h3FF, 10'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
		cell_queue.push_back(mk(10'd0, 10'h3FF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
		wait_drained();
		write_reg(REG_LEVEL, 16'h8000);
		write_reg(REG_CELL_W, 16'd0);
		write_reg(REG_CELL_H, 16'd0);
		cell_queue.push_back(mk(10'd9, 10'd9, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
		cell_queue.push_back(mk(10'd9, 10'd9, 16'h8000, 16'd0, 16'd0, 16'h8000));
		wait_drained();

		// random phases with varied settings
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(REG_LEVEL, (ph == 0) ? 16'h0000 : 16'($urandom));
			write_reg(REG_CELL_W, (ph < 3) ? 16'($urandom_range(0, 2048)) : 16'($urandom));
			write_reg(REG_CELL_H, (ph < 3) ? 16'($urandom_range(0, 2048)) : 16'($urandom));
			write_reg(REG_ORIGIN_X, 16'($urandom_range(0, 4095)));
			write_reg(REG_ORIGIN_Y, 16'($urandom_range(0, 4095)));
			lv = lvl_q;
			for (int i = 0; i < 38; i++)
				cell_queue.push_back(rand_cell(lv));
			wait_drained();
		end

		if (errors == 0)
			$display("contour_cell_segment_extract test passed");
		else
			$display("contour_cell_segment_extract test failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/ccse_pkg.sv
rtl/core/ccse_div.sv
rtl/core/contour_cell_segment_extract.sv
verif/tb.sv
